@@ hw/rtl/tass_pkg.sv @@
// shared widths, register indexes and reset values for the segment step timing block
package tass_pkg;

  // fixed field widths
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned STEPS_W    = 32;
  localparam int unsigned SCALE_W    = 10;
  localparam int unsigned MINP_W     = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd1;

  // register reset values
  localparam logic [MINP_W-1:0]  MINP_RESET  = 16'd500;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd100;

endpackage

@@ hw/rtl/two_axis_segment_step_timing_top.sv @@
// two-axis segment step counts and step periods, iterative shift-add and restoring divide
//
// Usage
//   Input channel (in_valid_i / in_ready_o) takes one path point per transfer, signed
//   fixed point with FRAC_BITS fraction bits. The first point after reset is only stored.
//   Every later point closes a segment and gives one result on the output channel
//   (out_valid_o / out_ready_i): signed step counts and step periods for both axes.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are always taken: index 0 sets the
//   minimum period, index 1 the scale. Write them only while the block is idle.
// Sequence
//   A segment runs through the accept step, the scale multiply for x and then y, a
//   round/select step, the shift-add loop for major * min_period (one step per bit of
//   min_period), the dividend and overflow check steps, PERIOD_BITS restoring divide
//   steps and the load of the output register; only then is the next point taken.
//   The shift-add, dividend, overflow and divide steps share one wide adder. A segment
//   with no minor axis movement goes from the round/select step straight to the load,
//   one with a saturating quotient from the overflow check. A point that only gets
//   stored leaves the sequencer idle.
// Reset and stall
//   Reset restores min_period 500, scale 100 and forgets the previous point.
//   in_ready_o is high only when the sequencer is idle. A finished result sits in the
//   output register; a stalled receiver holds the next result back in the last step.
module two_axis_segment_step_timing_top
  import tass_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned PERIOD_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input points
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_W-1:0]     point_x_i,
  input  logic signed [COORD_W-1:0]     point_y_i,
  // segment results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [STEPS_W-1:0]     steps_x_o,
  output logic signed [STEPS_W-1:0]     steps_y_o,
  output logic        [PERIOD_BITS-1:0] period_x_o,
  output logic        [PERIOD_BITS-1:0] period_y_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic        [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic        [CFG_DATA_W-1:0]  cfg_data_i
);

  // datapath widths
  localparam int unsigned DW     = COORD_W + 1;       // difference magnitude
  localparam int unsigned MW     = DW + SCALE_W;      // scaled magnitude
  localparam int unsigned NUMW   = MW + MINP_W + 1;   // dividend 2*num + minor
  localparam int unsigned AW     = NUMW + 1;          // shared adder, top bit is sign
  localparam int unsigned CNT_W  = $clog2(PERIOD_BITS);
  localparam int unsigned MPI_W  = $clog2(MINP_W);

  localparam logic [MW:0] HALF    = ((MW+1)'(1) << FRAC_BITS) >> 1;
  localparam logic [MW:0] SAT_NEG = (MW+1)'(1) << (STEPS_W - 1);
  localparam logic [MW:0] SAT_POS = SAT_NEG - (MW+1)'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULX,
    S_MULY,
    S_ROUND,
    S_PMUL,
    S_PREP,
    S_OVF,
    S_DIV,
    S_DONE
  } state_e;

  // round half away from zero and saturate to the signed step range
  function automatic logic [STEPS_W-1:0] round_steps(input logic [MW-1:0] mag,
                                                     input logic          neg);
    logic [MW:0] q;
    q = ({1'b0, mag} + HALF) >> FRAC_BITS;
    if (neg) begin
      if (q > SAT_NEG) q = SAT_NEG;
      return STEPS_W'((~q) + (MW+1)'(1));
    end else begin
      if (q > SAT_POS) q = SAT_POS;
      return q[STEPS_W-1:0];
    end
  endfunction

  state_e               state_q, state_d;
  logic [MINP_W-1:0]    minp_q, minp_d;
  logic [SCALE_W-1:0]   scale_q, scale_d;
  logic [COORD_W-1:0]   last_x_q, last_x_d, last_y_q, last_y_d;
  logic                 have_last_q, have_last_d;
  logic [DW-1:0]        magx_q, magx_d, magy_q, magy_d;
  logic                 negx_q, negx_d, negy_q, negy_d;
  logic [MW-1:0]        mx_q, mx_d, my_q, my_d;
  logic [MW-1:0]        major_q, major_d, minor_q, minor_d;
  logic                 minor_is_x_q, minor_is_x_d;
  logic [STEPS_W-1:0]   stx_q, stx_d, sty_q, sty_d;
  logic [NUMW-1:0]      acc_q, acc_d;
  logic [MW:0]          rem_q, rem_d;
  logic [PERIOD_BITS-1:0] nlo_q, nlo_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic [STEPS_W-1:0]   steps_x_q, steps_x_d, steps_y_q, steps_y_d;
  logic [PERIOD_BITS-1:0] period_x_q, period_x_d, period_y_q, period_y_d;

  logic [DW-1:0]        dx, dy;
  logic [DW-1:0]        mul_mag;
  logic [MW-1:0]        prod;
  logic [MW:0]          den;
  logic [NUMW-1:0]      acc_shr;
  logic [PERIOD_BITS-1:0] minp_ext;
  logic [AW-1:0]        alu_a, alu_b, alu_sum;
  logic                 alu_sub;
  logic                 alu_ge;

  // axis differences at the point transfer
  assign dx = {point_x_i[COORD_W-1], point_x_i} - {last_x_q[COORD_W-1], last_x_q};
  assign dy = {point_y_i[COORD_W-1], point_y_i} - {last_y_q[COORD_W-1], last_y_q};

  // scale multiplier, one axis a cycle
  assign mul_mag = (state_q == S_MULX) ? magx_q : magy_q;
  assign prod    = {{SCALE_W{1'b0}}, mul_mag} * {{DW{1'b0}}, scale_q};

  assign den      = {minor_q, 1'b0};
  assign acc_shr  = acc_q >> PERIOD_BITS;
  assign minp_ext = PERIOD_BITS'(minp_q);

  // shared add/subtract unit operand selection
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_PMUL: begin
        alu_a = AW'({acc_q, 1'b0});
        alu_b = minp_q[cnt_q[MPI_W-1:0]] ? AW'(major_q) : '0;
      end
      S_PREP: begin
        alu_a = AW'({acc_q, 1'b0});
        alu_b = AW'(minor_q);
      end
      S_OVF: begin
        alu_a   = AW'(acc_shr);
        alu_b   = AW'(den);
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = AW'({rem_q, nlo_q[PERIOD_BITS-1]});
        alu_b   = AW'(den);
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);
  assign alu_ge  = ~alu_sum[AW-1];

  // sequencer and register next values
  always_comb begin
    state_d      = state_q;
    minp_d       = minp_q;
    scale_d      = scale_q;
    last_x_d     = last_x_q;
    last_y_d     = last_y_q;
    have_last_d  = have_last_q;
    magx_d       = magx_q;
    magy_d       = magy_q;
    negx_d       = negx_q;
    negy_d       = negy_q;
    mx_d         = mx_q;
    my_d         = my_q;
    major_d      = major_q;
    minor_d      = minor_q;
    minor_is_x_d = minor_is_x_q;
    stx_d        = stx_q;
    sty_d        = sty_q;
    acc_d        = acc_q;
    rem_d        = rem_q;
    nlo_d        = nlo_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    steps_x_d    = steps_x_q;
    steps_y_d    = steps_y_q;
    period_x_d   = period_x_q;
    period_y_d   = period_y_q;

    // configuration writes
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_PERIOD: minp_d  = cfg_data_i[MINP_W-1:0];
        CFG_SCALE:      scale_d = cfg_data_i[SCALE_W-1:0];
        default:        minp_d  = minp_q;
      endcase
    end

    case (state_q)
      // point transfer: store it, start a segment if there was a previous point
      S_IDLE: begin
        if (in_valid_i) begin
          last_x_d    = point_x_i;
          last_y_d    = point_y_i;
          have_last_d = 1'b1;
          negx_d      = dx[DW-1];
          negy_d      = dy[DW-1];
          magx_d      = dx[DW-1] ? (~dx + DW'(1)) : dx;
          magy_d      = dy[DW-1] ? (~dy + DW'(1)) : dy;
          if (have_last_q) state_d = S_MULX;
        end
      end
      S_MULX: begin
        mx_d    = prod;
        state_d = S_MULY;
      end
      S_MULY: begin
        my_d    = prod;
        state_d = S_ROUND;
      end
      // step counts and choice of dominant axis
      S_ROUND: begin
        stx_d = round_steps(mx_q, negx_q);
        sty_d = round_steps(my_q, negy_q);
        if (my_q > mx_q) begin
          major_d      = my_q;
          minor_d      = mx_q;
          minor_is_x_d = 1'b1;
        end else begin
          major_d      = mx_q;
          minor_d      = my_q;
          minor_is_x_d = 1'b0;
        end
        if ((my_q > mx_q ? mx_q : my_q) == '0) begin
          nlo_d   = minp_ext;
          state_d = S_DONE;
        end else begin
          acc_d   = '0;
          cnt_d   = CNT_W'(MINP_W - 1);
          state_d = S_PMUL;
        end
      end
      // major * min_period, one bit of min_period a cycle from the top
      S_PMUL: begin
        acc_d = alu_sum[NUMW-1:0];
        if (cnt_q == '0) begin
          state_d = S_PREP;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      // dividend for half-up rounding
      S_PREP: begin
        acc_d   = alu_sum[NUMW-1:0];
        state_d = S_OVF;
      end
      // quotient beyond the period range saturates
      S_OVF: begin
        if (alu_ge) begin
          nlo_d   = '1;
          state_d = S_DONE;
        end else begin
          rem_d   = acc_shr[MW:0];
          nlo_d   = acc_q[PERIOD_BITS-1:0];
          cnt_d   = CNT_W'(PERIOD_BITS - 1);
          state_d = S_DIV;
        end
      end
      // restoring divide, quotient bits shift in behind the dividend bits
      S_DIV: begin
        if (alu_ge) begin
          rem_d = alu_sum[MW:0];
        end else begin
          rem_d = {rem_q[MW-1:0], nlo_q[PERIOD_BITS-1]};
        end
        nlo_d = {nlo_q[PERIOD_BITS-2:0], alu_ge};
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      // load the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          steps_x_d   = stx_q;
          steps_y_d   = sty_q;
          period_x_d  = minor_is_x_q ? nlo_q : minp_ext;
          period_y_d  = minor_is_x_q ? minp_ext : nlo_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      minp_q       <= MINP_RESET;
      scale_q      <= SCALE_RESET;
      last_x_q     <= '0;
      last_y_q     <= '0;
      have_last_q  <= 1'b0;
      magx_q       <= '0;
      magy_q       <= '0;
      negx_q       <= 1'b0;
      negy_q       <= 1'b0;
      mx_q         <= '0;
      my_q         <= '0;
      major_q      <= '0;
      minor_q      <= '0;
      minor_is_x_q <= 1'b0;
      stx_q        <= '0;
      sty_q        <= '0;
      acc_q        <= '0;
      rem_q        <= '0;
      nlo_q        <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      steps_x_q    <= '0;
      steps_y_q    <= '0;
      period_x_q   <= '0;
      period_y_q   <= '0;
    end else begin
      state_q      <= state_d;
      minp_q       <= minp_d;
      scale_q      <= scale_d;
      last_x_q     <= last_x_d;
      last_y_q     <= last_y_d;
      have_last_q  <= have_last_d;
      magx_q       <= magx_d;
      magy_q       <= magy_d;
      negx_q       <= negx_d;
      negy_q       <= negy_d;
      mx_q         <= mx_d;
      my_q         <= my_d;
      major_q      <= major_d;
      minor_q      <= minor_d;
      minor_is_x_q <= minor_is_x_d;
      stx_q        <= stx_d;
      sty_q        <= sty_d;
      acc_q        <= acc_d;
      rem_q        <= rem_d;
      nlo_q        <= nlo_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      steps_x_q    <= steps_x_d;
      steps_y_q    <= steps_y_d;
      period_x_q   <= period_x_d;
      period_y_q   <= period_y_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign steps_x_o   = steps_x_q;
  assign steps_y_o   = steps_y_q;
  assign period_x_o  = period_x_q;
  assign period_y_o  = period_y_q;

endmodule

@@ verif/two_axis_segment_step_timing_checker.sv @@
// segment result predictor and scoreboard for the two-axis step timing block
`timescale 1ns / 100ps

module two_axis_segment_step_timing_checker
  import tass_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned PERIOD_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // point channel
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [COORD_W-1:0]     point_x_i,
  input  logic signed [COORD_W-1:0]     point_y_i,
  // result channel
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [STEPS_W-1:0]     steps_x_i,
  input  logic signed [STEPS_W-1:0]     steps_y_i,
  input  logic        [PERIOD_BITS-1:0] period_x_i,
  input  logic        [PERIOD_BITS-1:0] period_y_i,
  // register writes
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic        [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic        [CFG_DATA_W-1:0]  cfg_data_i,
  // status for the stimulus side
  output int                            pending_o,
  output int                            checked_o,
  output int                            fail_count_o
);

  typedef struct {
    logic signed [STEPS_W-1:0]     steps_x;
    logic signed [STEPS_W-1:0]     steps_y;
    logic        [PERIOD_BITS-1:0] period_x;
    logic        [PERIOD_BITS-1:0] period_y;
  } segment_t;

  // local copy of the registers and the stored point
  logic [MINP_W-1:0]         fast_period;
  logic [SCALE_W-1:0]        steps_per_unit;
  logic signed [COORD_W-1:0] prev_x;
  logic signed [COORD_W-1:0] prev_y;
  logic                      have_prev;

  segment_t pending_segments[$];
  segment_t want;
  int       n_expected;
  int       n_checked;
  int       fail_count = 0;

  assign pending_o    = n_expected - n_checked;
  assign checked_o    = n_checked;
  assign fail_count_o = fail_count;

  // scaled magnitude to a step count, half away from zero, clipped to 32 bits
  function automatic logic [STEPS_W-1:0] to_step_count(longint unsigned mag, bit neg);
    longint unsigned q;
    q = (mag + ((64'd1 << FRAC_BITS) >> 1)) >> FRAC_BITS;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      q = -q;
    end else if (q > 64'h7FFF_FFFF) begin
      q = 64'h7FFF_FFFF;
    end
    return q[STEPS_W-1:0];
  endfunction

  function automatic logic [PERIOD_BITS-1:0] cap_period(longint unsigned p);
    longint unsigned top;
    top = (64'd1 << PERIOD_BITS) - 1;
    return (p > top) ? top[PERIOD_BITS-1:0] : p[PERIOD_BITS-1:0];
  endfunction

  // slower axis: major * min_period / minor, rounded half up
  function automatic logic [PERIOD_BITS-1:0] trailing_axis_period(longint unsigned major,
                                                                   longint unsigned minor);
    longint unsigned num;
    if (minor == 0) return cap_period(fast_period);
    num = major * fast_period;
    return cap_period((64'd2 * num + minor) / (64'd2 * minor));
  endfunction

  // predicted result for the segment from the stored point to (px, py)
  function automatic segment_t segment_timing(logic signed [COORD_W-1:0] px,
                                              logic signed [COORD_W-1:0] py);
    segment_t        s;
    longint          dx;
    longint          dy;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned mx;
    longint unsigned my;
    dx = longint'(px) - longint'(prev_x);
    dy = longint'(py) - longint'(prev_y);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    mx = ax * steps_per_unit;
    my = ay * steps_per_unit;
    s.steps_x = to_step_count(mx, dx < 0);
    s.steps_y = to_step_count(my, dy < 0);
    // x leads on a tie
    if (my > mx) begin
      s.period_y = cap_period(fast_period);
      s.period_x = trailing_axis_period(my, mx);
    end else begin
      s.period_x = cap_period(fast_period);
      s.period_y = trailing_axis_period(mx, my);
    end
    return s;
  endfunction

  task automatic check_field(input string field, input longint expd, input longint got);
    if (expd != got) begin
      $error("%s: expected %0d, got %0d", field, expd, got);
      fail_count++;
    end
  endtask

  // watch all three channels; results are compared before a new point is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_period    = MINP_RESET;
      steps_per_unit = SCALE_RESET;
      prev_x         = '0;
      prev_y         = '0;
      have_prev      = 1'b0;
      pending_segments.delete();
      n_expected    <= 0;
      n_checked     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MIN_PERIOD: fast_period = cfg_data_i[MINP_W-1:0];
          CFG_SCALE:      steps_per_unit = cfg_data_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_segments.size() == 0) begin
          $error("segment result transfer with no segment outstanding");
          fail_count++;
        end else begin
          want = pending_segments.pop_front();
          check_field("steps_x", want.steps_x, steps_x_i);
          check_field("steps_y", want.steps_y, steps_y_i);
          check_field("period_x", want.period_x, period_x_i);
          check_field("period_y", want.period_y, period_y_i);
          n_checked <= n_checked + 1;
        end
      end
      if (in_valid_i && in_ready_i) begin
        // the first point only opens the path
        if (have_prev) begin
          pending_segments.insert(pending_segments.size(),
                                  segment_timing(point_x_i, point_y_i));
          n_expected <= n_expected + 1;
        end
        prev_x    = point_x_i;
        prev_y    = point_y_i;
        have_prev = 1'b1;
      end
    end
  end

endmodule

@@ verif/two_axis_segment_step_timing_top_tb.sv @@
// stimulus, clocking and verdict for the two-axis segment step timing block
`timescale 1ns / 100ps

module two_axis_segment_step_timing_top_tb
  import tass_pkg::*;
();

  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned PERIOD_BITS  = 24;
  localparam int unsigned RAND_PHASES  = 12;
  localparam int unsigned PHASE_POINTS = 115;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 1_200_000;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [COORD_W-1:0]     point_x = '0;
  logic signed [COORD_W-1:0]     point_y = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [STEPS_W-1:0]     steps_x;
  logic signed [STEPS_W-1:0]     steps_y;
  logic        [PERIOD_BITS-1:0] period_x;
  logic        [PERIOD_BITS-1:0] period_y;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic        [CFG_IDX_W-1:0]   cfg_index = '0;
  logic        [CFG_DATA_W-1:0]  cfg_data = '0;

  int          pending;
  int          checked;
  int          fail_count;
  int unsigned points_sent = 0;
  int unsigned settings_used = 0;
  int unsigned drains = 0;
  int unsigned cycles = 0;
  bit          hold_done = 1'b0;
  bit          burst = 1'b0;
  logic [31:0] last_px = '0;
  logic [31:0] last_py = '0;

  two_axis_segment_step_timing_top #(
    .FRAC_BITS  (FRAC_BITS),
    .PERIOD_BITS(PERIOD_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .point_x_i  (point_x),
    .point_y_i  (point_y),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .steps_x_o  (steps_x),
    .steps_y_o  (steps_y),
    .period_x_o (period_x),
    .period_y_o (period_y),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  two_axis_segment_step_timing_checker #(
    .FRAC_BITS  (FRAC_BITS),
    .PERIOD_BITS(PERIOD_BITS)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .point_x_i   (point_x),
    .point_y_i   (point_y),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .steps_x_i   (steps_x),
    .steps_y_i   (steps_y),
    .period_x_i  (period_x),
    .period_y_i  (period_y),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .checked_o   (checked),
    .fail_count_o(fail_count)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // run guard
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[two_axis_segment_step_timing_top] ERROR");
    $finish;
  end

  // sender idle gaps: mostly none, some short, a few long
  function automatic int unsigned sender_gap();
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [31:0] rand_delta(int unsigned bits);
    logic [31:0] m;
    m = $urandom() & ((bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1));
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic logic [31:0] edge_coord();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0001;
      default: return 32'h8000_0001;
    endcase
  endfunction

  // one point transfer, then an idle gap; valid stays up when no gap follows
  task automatic send_point(input logic [31:0] x, input logic [31:0] y);
    int unsigned gap;
    in_valid <= 1'b1;
    point_x  <= x;
    point_y  <= y;
    do @(posedge clk); while (!in_ready);
    points_sent++;
    last_px = x;
    last_py = y;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering points until every outstanding segment has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    drains++;
  endtask

  // drained and settled, so register writes land on an idle block
  task automatic quiesce();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stalls, full-speed stretches and one long hold-off
  initial begin : receiver
    int unsigned stall;
    int unsigned free_left;
    int unsigned r;
    stall     = 0;
    free_left = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!hold_done && points_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        stall     = HOLD_CYCLES;
      end else if (stall == 0 && free_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 20)      free_left = $urandom_range(20, 150);
        else if (r < 45) stall = $urandom_range(1, 3);
        else if (r < 50) stall = $urandom_range(20, 80);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (free_left != 0) free_left--;
      end
      @(posedge clk);
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned r;
    int unsigned kind;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] d;
    logic [CFG_DATA_W-1:0] pick;
    do @(posedge clk); while (!rst_n);

    // reset settings: first point, zero length, extreme coordinates, ties,
    // one axis still, saturating slow-axis period
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFE);
    send_point(32'h0000_0000, 32'h7FFF_FFFF);
    settings_used++;

    // unit scale and period: half-way rounding of steps and of the divide
    quiesce();
    write_reg(CFG_MIN_PERIOD, 16'd1);
    write_reg(CFG_SCALE, 16'd1);
    settings_used++;
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h0000_8000, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h0000_7FFF, 32'h0001_8000);
    send_point(32'h0000_8002, 32'h0001_8002);

    // zero period and zero scale
    quiesce();
    write_reg(CFG_MIN_PERIOD, 16'd0);
    write_reg(CFG_SCALE, 16'd0);
    settings_used++;
    send_point(32'h0001_E240, 32'hFFFE_7E33);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    quiesce();
    write_reg(CFG_SCALE, 16'd5);
    settings_used++;
    send_point(32'h0001_0000, 32'h0003_0000);
    send_point(32'hFFF0_0000, 32'h0000_4000);

    // largest settings, spare indexes, largest moves
    quiesce();
    write_reg(CFG_MIN_PERIOD, 16'hFFFF);
    write_reg(CFG_SCALE, 16'hFFFF);
    write_reg(CFG_SPARE_A, 16'($urandom));
    write_reg(CFG_SPARE_B, 16'($urandom));
    settings_used++;
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFE);

    // random phases, each with its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      quiesce();
      r = $urandom_range(0, 99);
      if (r >= 15) begin
        case ($urandom_range(0, 9))
          0:       pick = 16'd1;
          1:       pick = 16'hFFFF;
          2, 3:    pick = 16'($urandom_range(1, 20));
          default: pick = 16'($urandom_range(1, 65535));
        endcase
        write_reg(CFG_MIN_PERIOD, pick);
      end
      if (r < 15 || r >= 30) begin
        // upper data bits are noise for the scale register
        pick = 16'($urandom);
        case ($urandom_range(0, 9))
          0:       pick[SCALE_W-1:0] = 10'd1;
          1:       pick[SCALE_W-1:0] = 10'd1023;
          2, 3:    pick[SCALE_W-1:0] = 10'($urandom_range(1, 8));
          default: pick[SCALE_W-1:0] = 10'($urandom_range(1, 1023));
        endcase
        write_reg(CFG_SCALE, pick);
      end
      settings_used++;
      burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_POINTS; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
          nx = $urandom();
          ny = $urandom();
        end else if (kind < 55) begin
          // short move along the path
          nx = last_px + rand_delta($urandom_range(0, 24));
          ny = last_py + rand_delta($urandom_range(0, 24));
        end else if (kind < 65) begin
          // one axis still
          d = rand_delta($urandom_range(0, 31));
          if ($urandom_range(0, 1)) begin
            nx = last_px + d;
            ny = last_py;
          end else begin
            nx = last_px;
            ny = last_py + d;
          end
        end else if (kind < 75) begin
          // equal magnitudes
          d  = rand_delta($urandom_range(0, 28));
          nx = last_px + d;
          ny = last_py + ($urandom_range(0, 1) ? d : -d);
        end else if (kind < 80) begin
          nx = last_px;
          ny = last_py;
        end else if (kind < 90) begin
          nx = edge_coord();
          ny = edge_coord();
        end else begin
          // half-unit fractions
          d  = (32'($urandom_range(0, 1023)) << FRAC_BITS) + 32'h0000_8000;
          nx = last_px + ($urandom_range(0, 1) ? d : -d);
          d  = (32'($urandom_range(0, 1023)) << FRAC_BITS) + 32'h0000_8000;
          ny = last_py + ($urandom_range(0, 1) ? d : -d);
        end
        send_point(nx, ny);
        if ($urandom_range(0, 99) == 0) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d points and %0d segment results over %0d register settings",
             points_sent, checked, settings_used);
    $display("with %0d full drains and a %0d-cycle receiver hold-off", drains, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("[two_axis_segment_step_timing_top] OK");
    end else begin
      $display("[two_axis_segment_step_timing_top] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tass_pkg.sv
hw/rtl/two_axis_segment_step_timing_top.sv
verif/two_axis_segment_step_timing_checker.sv
verif/two_axis_segment_step_timing_top_tb.sv
